// ===== rtl/core/qerpm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qerpm_pkg
// Shared types and constants for the quadrature encoder rpm meter core.
// ----------------------------------------------------------------------------
package qerpm_pkg;

    localparam int COUNT_BITS   = 32;
    localparam int TIME_W       = 32;
    localparam int TMO_W        = 24;
    localparam int RAW_W        = TIME_W + 1;
    localparam int PERIOD_W     = TMO_W + 1;
    localparam int RPM_W        = 20;
    localparam int STEP_W       = 32;
    localparam int DATA_W       = 32;
    localparam int PADDR_W      = 3;

    localparam logic [TMO_W-1:0] TIMEOUT_RESET = TMO_W'(100000);

    // floor(60000000 / 225); floor(floor(n/a)/b) equals floor(n/(a*b))
    localparam int RPM_NUM_INT  = 60000000 / 225;
    localparam int QUO_W        = $clog2(RPM_NUM_INT + 1);
    localparam int DIV_STEPS    = QUO_W;
    localparam int CNT_W        = $clog2(DIV_STEPS);
    localparam logic [QUO_W-1:0] RPM_NUM = QUO_W'(RPM_NUM_INT);

    // register index taken from paddr[2]
    localparam logic REG_DIRECTION = 1'b0;
    localparam logic REG_TIMEOUT   = 1'b1;

    localparam logic FUNC_EDGE   = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CLAMP,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic clamp;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_update;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/core/qerpm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qerpm_ctrl
// Sequencer: capture, state update, clamp, iterative divide, result load.
// ----------------------------------------------------------------------------
module qerpm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  qerpm_pkg::t_sts   i_sts,
    output qerpm_pkg::t_cmd   o_cmd
);
    import qerpm_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.is_update ? ST_CLAMP : ST_IDLE;
            end
            ST_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_cnt       = '0;
                n_state     = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/qerpm_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qerpm_dp
// Datapath: step counter, edge timing, timeout, clamp, restoring divider
// and the output register.
// ----------------------------------------------------------------------------
module qerpm_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  qerpm_pkg::t_cmd                       i_cmd,
    output qerpm_pkg::t_sts                       o_sts,
    input  logic                                  i_direction_level,
    input  logic [qerpm_pkg::TMO_W-1:0]           i_timeout_us,
    input  logic                                  i_func,
    input  logic                                  i_b_level,
    input  logic [qerpm_pkg::TIME_W-1:0]          i_time_us,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [qerpm_pkg::STEP_W-1:0]   o_step_total,
    output logic signed [qerpm_pkg::PERIOD_W-1:0] o_step_period,
    output logic signed [qerpm_pkg::RPM_W-1:0]    o_speed_rpm,
    output logic                                  o_zero_period
);
    import qerpm_pkg::*;

    // captured transaction
    logic                       r_func;
    logic                       r_b_level;
    logic [TIME_W-1:0]          r_time;

    // block state
    logic [COUNT_BITS-1:0]      r_step_cnt;
    logic [TIME_W-1:0]          r_last_time;
    logic signed [RAW_W-1:0]    r_raw;

    // clamp results
    logic signed [PERIOD_W-1:0] r_period;
    logic [TMO_W-1:0]           r_mag;
    logic                       r_fast;
    logic                       r_zero;
    logic                       r_pos;

    // divider
    logic [TMO_W-1:0]           r_rem;
    logic [QUO_W-1:0]           r_dvd;
    logic [QUO_W-1:0]           r_quo;

    // output register
    logic                       r_out_valid;
    logic signed [STEP_W-1:0]   r_out_step;
    logic signed [PERIOD_W-1:0] r_out_period;
    logic signed [RPM_W-1:0]    r_out_rpm;
    logic                       r_out_zero;

    logic [TIME_W-1:0]          w_delta;
    logic                       w_timeout;
    logic signed [RAW_W-1:0]    w_tmo_s;
    logic signed [RAW_W-1:0]    w_clamped;
    logic signed [PERIOD_W-1:0] w_period;
    logic [TMO_W+1:0]           w_diff;
    logic                       w_borrow;
    logic signed [RPM_W-1:0]    w_quo_s;

    assign w_delta   = r_time - r_last_time;
    assign w_timeout = (w_delta >= TIME_W'(i_timeout_us));
    assign w_tmo_s   = signed'(RAW_W'(i_timeout_us));

    always_comb begin
        if (r_raw > w_tmo_s) begin
            w_clamped = w_tmo_s;
        end else if (r_raw < -w_tmo_s) begin
            w_clamped = -w_tmo_s;
        end else begin
            w_clamped = r_raw;
        end
    end
    assign w_period = w_clamped[PERIOD_W-1:0];

    assign w_diff   = {1'b0, r_rem, r_dvd[QUO_W-1]} - {2'b00, r_mag};
    assign w_borrow = w_diff[TMO_W+1];
    assign w_quo_s  = signed'(RPM_W'(r_quo));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func    <= i_func;
            r_b_level <= i_b_level;
            r_time    <= i_time_us;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_cnt  <= '0;
            r_last_time <= '0;
            r_raw       <= '0;
        end else if (i_cmd.exec) begin
            if (r_func == FUNC_EDGE) begin
                r_last_time <= r_time;
                if (r_b_level == i_direction_level) begin
                    r_step_cnt <= r_step_cnt + COUNT_BITS'(1);
                    r_raw      <= signed'({1'b0, w_delta});
                end else begin
                    r_step_cnt <= r_step_cnt - COUNT_BITS'(1);
                    r_raw      <= -signed'({1'b0, w_delta});
                end
            end else if (w_timeout) begin
                r_raw       <= w_tmo_s;
                r_last_time <= r_time;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clamp) begin
            r_period <= w_period;
            r_mag    <= w_period[PERIOD_W-1] ? TMO_W'(-w_period) : TMO_W'(w_period);
            r_fast   <= (r_raw < w_tmo_s) && (i_timeout_us != '0);
            r_zero   <= (r_raw == '0) && (i_timeout_us != '0);
            r_pos    <= !r_raw[RAW_W-1];
            r_rem    <= '0;
            r_dvd    <= RPM_NUM;
            r_quo    <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_borrow ? {r_rem[TMO_W-2:0], r_dvd[QUO_W-1]} : w_diff[TMO_W-1:0];
            r_dvd <= {r_dvd[QUO_W-2:0], 1'b0};
            r_quo <= {r_quo[QUO_W-2:0], !w_borrow};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_step   <= signed'(STEP_W'(r_step_cnt));
            r_out_period <= r_period;
            r_out_zero   <= r_zero;
            if (r_fast && !r_zero) begin
                r_out_rpm <= r_pos ? -w_quo_s : w_quo_s;
            end else begin
                r_out_rpm <= '0;
            end
        end
    end

    assign o_sts.is_update = (r_func == FUNC_UPDATE);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_step_total  = r_out_step;
    assign o_step_period = r_out_period;
    assign o_speed_rpm   = r_out_rpm;
    assign o_zero_period = r_out_zero;

endmodule

// ===== rtl/core/quadrature_encoder_rpm_meter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_encoder_rpm_meter_core
// Counts signed encoder steps, times the last edge period and converts the
// clamped period to rpm with a bit-serial divider.
// ----------------------------------------------------------------------------
// channel   handshake                  payload
// input     i_in_valid / o_in_ready    i_func, i_b_level, i_time_us
// output    o_out_valid / i_out_ready  o_step_total, o_step_period,
//                                      o_speed_rpm, o_zero_period
// config    apb psel/penable/pready    paddr, pwdata, prdata
//
// edge transaction: capture, state update
// update transaction adds clamp, restoring divider and result load
// a finished result waits in the output register; the next transaction is
// taken meanwhile; a new update result waits in ST_DONE until it is free
// synchronous active-low reset, no clearing pass
// ----------------------------------------------------------------------------
module quadrature_encoder_rpm_meter_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [qerpm_pkg::PADDR_W-1:0]         paddr,
    input  logic [qerpm_pkg::DATA_W-1:0]          pwdata,
    output logic [qerpm_pkg::DATA_W-1:0]          prdata,
    output logic                                  pready,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_func,
    input  logic                                  i_b_level,
    input  logic [qerpm_pkg::TIME_W-1:0]          i_time_us,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [qerpm_pkg::STEP_W-1:0]   o_step_total,
    output logic signed [qerpm_pkg::PERIOD_W-1:0] o_step_period,
    output logic signed [qerpm_pkg::RPM_W-1:0]    o_speed_rpm,
    output logic                                  o_zero_period
);
    import qerpm_pkg::*;

    logic             r_direction_level;
    logic [TMO_W-1:0] r_timeout_us;
    logic             w_wr;
    logic             w_reg_idx;
    t_cmd             w_cmd;
    t_sts             w_sts;

    assign pready    = 1'b1;
    assign w_wr      = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction_level <= 1'b0;
            r_timeout_us      <= TIMEOUT_RESET;
        end else if (w_wr) begin
            case (w_reg_idx)
                REG_DIRECTION: r_direction_level <= pwdata[0];
                REG_TIMEOUT:   r_timeout_us      <= pwdata[TMO_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_DIRECTION: prdata = DATA_W'(r_direction_level);
            REG_TIMEOUT:   prdata = DATA_W'(r_timeout_us);
            default:       prdata = '0;
        endcase
    end

    qerpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    qerpm_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_direction_level (r_direction_level),
        .i_timeout_us      (r_timeout_us),
        .i_func            (i_func),
        .i_b_level         (i_b_level),
        .i_time_us         (i_time_us),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_step_total      (o_step_total),
        .o_step_period     (o_step_period),
        .o_speed_rpm       (o_speed_rpm),
        .o_zero_period     (o_zero_period)
    );

    a_zero_no_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_zero_period) |-> (o_speed_rpm == '0))
        else $error("zero period with nonzero speed");

    a_speed_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_speed_rpm != '0)) |->
        (o_speed_rpm[RPM_W-1] != o_step_period[PERIOD_W-1]))
        else $error("speed sign does not oppose period sign");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("transaction taken while busy");

endmodule

// ===== dv/tb_quadrature_encoder_rpm_meter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quadrature_encoder_rpm_meter_core
// Self-checking testbench for the encoder rpm meter core. Edge and update
// transactions are driven over valid/ready, and a behavioral predictor keeps
// its own step count, edge time and period. Each update result is compared
// field by field with the oldest prediction. The register port is written
// only while the core is idle, and the run covers several idle/stall mixes,
// a long output hold-off and timeout settings from zero to the maximum.
// ----------------------------------------------------------------------------
module tb_quadrature_encoder_rpm_meter_core;
    import qerpm_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 5000;
    localparam int HOLDOFF_LEN   = 300;
    localparam int PHASE_ITEMS   = 400;

    typedef struct packed {
        logic signed [STEP_W-1:0]   steps;
        logic signed [PERIOD_W-1:0] period;
        logic signed [RPM_W-1:0]    rpm;
        logic                       zero;
    } t_speed_reading;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_func;
    logic                 i_b_level;
    logic [TIME_W-1:0]    i_time_us;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic signed [STEP_W-1:0]   o_step_total;
    logic signed [PERIOD_W-1:0] o_step_period;
    logic signed [RPM_W-1:0]    o_speed_rpm;
    logic                       o_zero_period;

    // predictor state and register copies
    logic [STEP_W-1:0] enc_steps;
    logic [TIME_W-1:0] enc_last_time;
    longint            enc_raw_period;
    logic              cfg_dir;
    logic [TMO_W-1:0]  cfg_timeout;

    t_speed_reading expected_readings[$];

    int send_idle_pct;
    int recv_stall_pct;
    int ready_holdoff;
    int mismatches;
    int n_edges;
    int n_updates;
    int n_results;
    int n_timeouts;
    int n_zero;
    int idle_cycles;
    logic [TIME_W-1:0] stamp_now;
    logic              run_b;

    quadrature_encoder_rpm_meter_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_b_level     (i_b_level),
        .i_time_us     (i_time_us),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_step_total  (o_step_total),
        .o_step_period (o_step_period),
        .o_speed_rpm   (o_speed_rpm),
        .o_zero_period (o_zero_period)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic bit predict_reading(input logic func, input logic blev,
                                           input logic [TIME_W-1:0] stamp,
                                           output t_speed_reading r);
        logic [TIME_W-1:0] delta;
        longint            tmo;
        longint            period;
        longint            quo;
        delta = stamp - enc_last_time;
        tmo   = longint'(cfg_timeout);
        r     = '0;
        if (func == FUNC_EDGE) begin
            if (blev == cfg_dir) begin
                enc_steps      = enc_steps + 1'b1;
                enc_raw_period = longint'(delta);
            end else begin
                enc_steps      = enc_steps - 1'b1;
                enc_raw_period = -longint'(delta);
            end
            enc_last_time = stamp;
            return 1'b0;
        end
        if (longint'(delta) >= tmo) begin
            enc_raw_period = tmo;
            enc_last_time  = stamp;
            n_timeouts++;
        end
        period = enc_raw_period;
        if (period > tmo) period = tmo;
        if (period < -tmo) period = -tmo;
        if (period < tmo) begin
            if (period == 0) begin
                r.zero = 1'b1;
            end else begin
                quo   = -64'sd60000000 / (64'sd225 * period);
                r.rpm = quo[RPM_W-1:0];
            end
        end
        r.steps  = enc_steps;
        r.period = period[PERIOD_W-1:0];
        return 1'b1;
    endfunction

    task automatic send_sample(input logic func, input logic blev,
                               input logic [TIME_W-1:0] stamp);
        t_speed_reading r;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_func     = func;
        i_b_level  = blev;
        i_time_us  = stamp;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (predict_reading(func, blev, stamp, r)) begin
            expected_readings.push_back(r);
            n_updates++;
        end else begin
            n_edges++;
        end
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic wait_idle();
        while (expected_readings.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic reg_sel, input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_sel, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (reg_sel == REG_DIRECTION) cfg_dir = value[0];
        else cfg_timeout = value[TMO_W-1:0];
    endtask

    // next timestamp: mostly short steps, some near the timeout, some random
    function automatic logic [TIME_W-1:0] next_stamp();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 60) stamp_now = stamp_now + $urandom_range(1, 3000);
        else if (pick < 75) stamp_now = stamp_now + cfg_timeout + $urandom_range(0, 4) - 2;
        else if (pick < 85) stamp_now = stamp_now;
        else if (pick < 95) stamp_now = stamp_now + $urandom_range(1, 2 * cfg_timeout + 1);
        else stamp_now = $urandom();
        return stamp_now;
    endfunction

    task automatic test_directed_speed();
        send_sample(FUNC_UPDATE, 1'b0, 32'd0);
        send_sample(FUNC_EDGE,   1'b0, 32'd1);
        send_sample(FUNC_UPDATE, 1'b1, 32'd2);
        send_sample(FUNC_EDGE,   1'b1, 32'd2);
        send_sample(FUNC_UPDATE, 1'b0, 32'd3);
        send_sample(FUNC_EDGE,   1'b0, 32'd100002);
        send_sample(FUNC_UPDATE, 1'b0, 32'd100003);
        send_sample(FUNC_EDGE,   1'b1, 32'd600003);
        send_sample(FUNC_UPDATE, 1'b0, 32'd600004);
        send_sample(FUNC_EDGE,   1'b0, 32'd700003);
        send_sample(FUNC_UPDATE, 1'b0, 32'd700003);
        send_sample(FUNC_UPDATE, 1'b1, 32'd800003);
        send_sample(FUNC_UPDATE, 1'b0, 32'hFFFF_FFFF);
        send_sample(FUNC_EDGE,   1'b1, 32'hFFFF_FFFF);
        send_sample(FUNC_EDGE,   1'b0, 32'h0000_0005);
        send_sample(FUNC_UPDATE, 1'b0, 32'h0000_0006);
        send_sample(FUNC_EDGE,   1'b1, 32'h0000_0006);
        send_sample(FUNC_EDGE,   1'b0, 32'h0000_0006);
        send_sample(FUNC_UPDATE, 1'b0, 32'h0000_0006);
        wait_idle();
    endtask

    task automatic test_register_settings();
        write_register(REG_DIRECTION, 32'd1);
        write_register(REG_TIMEOUT, 32'd1);
        send_sample(FUNC_EDGE,   1'b1, 32'd100);
        send_sample(FUNC_EDGE,   1'b0, 32'd100);
        send_sample(FUNC_UPDATE, 1'b0, 32'd100);
        send_sample(FUNC_EDGE,   1'b0, 32'd101);
        send_sample(FUNC_UPDATE, 1'b0, 32'd101);
        send_sample(FUNC_UPDATE, 1'b0, 32'd102);
        wait_idle();
        write_register(REG_TIMEOUT, 32'hFFFF_FFFF);
        send_sample(FUNC_EDGE,   1'b1, 32'd102 + 32'd16777214);
        send_sample(FUNC_UPDATE, 1'b0, 32'd102 + 32'd16777214);
        send_sample(FUNC_EDGE,   1'b0, 32'd102 + 32'd16777214 * 2);
        send_sample(FUNC_UPDATE, 1'b0, 32'd103 + 32'd16777214 * 2);
        send_sample(FUNC_EDGE,   1'b1, 32'd403 + 32'd16777214 * 2);
        send_sample(FUNC_UPDATE, 1'b0, 32'd403 + 32'd16777214 * 3);
        wait_idle();
        // zero timeout is out of range but must still time out every update
        write_register(REG_TIMEOUT, 32'd0);
        send_sample(FUNC_UPDATE, 1'b0, 32'd5);
        send_sample(FUNC_EDGE,   1'b0, 32'd6);
        send_sample(FUNC_UPDATE, 1'b1, 32'd6);
        wait_idle();
    endtask

    task automatic test_random_traffic(input int idle_s, input int idle_r,
                                       input logic dir, input logic [DATA_W-1:0] tmo);
        logic func;
        logic blev;
        wait_idle();
        write_register(REG_DIRECTION, {31'b0, dir});
        write_register(REG_TIMEOUT, tmo);
        send_idle_pct  = idle_s;
        recv_stall_pct = idle_r;
        stamp_now      = enc_last_time;
        repeat (PHASE_ITEMS) begin
            func = ($urandom_range(99) < 30) ? FUNC_UPDATE : FUNC_EDGE;
            if ($urandom_range(99) < 5) run_b = ~run_b;
            blev = ($urandom_range(99) < 10) ? 1'($urandom()) : run_b;
            send_sample(func, blev, next_stamp());
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        wait_idle();
        ready_holdoff = HOLDOFF_LEN;
        repeat (12) send_sample(FUNC_UPDATE, 1'b0, next_stamp());
        repeat (6) begin
            send_sample(FUNC_EDGE, run_b, next_stamp());
            send_sample(FUNC_UPDATE, 1'b0, next_stamp());
        end
        wait_idle();
    endtask

    // receiver side
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (ready_holdoff > 0) begin
                i_out_ready   = 1'b0;
                ready_holdoff = ready_holdoff - 1;
            end else begin
                i_out_ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_speed_reading got;
        t_speed_reading want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_step_total, o_step_period, o_speed_rpm, o_zero_period};
            n_results++;
            if (got.zero) n_zero++;
            if (expected_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with none pending: steps %0d period %0d",
                             $time, got.steps, got.period, " rpm %0d zero %0b",
                             got.rpm, got.zero);
            end else begin
                want = expected_readings.pop_front();
                if (got.steps !== want.steps || got.period !== want.period ||
                    got.rpm !== want.rpm || got.zero !== want.zero) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: mismatch exp steps %0d period %0d rpm %0d zero %0b,",
                                 $time, want.steps, want.period, want.rpm, want.zero,
                                 " got steps %0d period %0d rpm %0d zero %0b",
                                 got.steps, got.period, got.rpm, got.zero);
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    initial begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        i_in_valid     = 1'b0;
        i_func         = FUNC_EDGE;
        i_b_level      = 1'b0;
        i_time_us      = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        ready_holdoff  = 0;
        mismatches     = 0;
        n_edges        = 0;
        n_updates      = 0;
        n_results      = 0;
        n_timeouts     = 0;
        n_zero         = 0;
        run_b          = 1'b0;
        stamp_now      = '0;
        enc_steps      = '0;
        enc_last_time  = '0;
        enc_raw_period = 0;
        cfg_dir        = 1'b0;
        cfg_timeout    = TIMEOUT_RESET;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_speed();
        test_register_settings();
        test_random_traffic(0, 0, 1'b0, 32'd100000);
        test_random_traffic(79, 0, 1'b1, 32'd500);
        test_random_traffic(0, 79, 1'($urandom()), 32'd16777215);
        test_random_traffic(9, 9, 1'($urandom()), $urandom_range(2, 200000));
        test_backpressure();
        wait_idle();

        $display("covered %0d edge and %0d update transactions, %0d results checked",
                 n_edges, n_updates, n_results);
        $display("%0d timeouts, %0d zero periods, timeouts 0 to max, four idle mixes, %0d errors",
                 n_timeouts, n_zero, mismatches);
        if (mismatches == 0 && expected_readings.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/qerpm_pkg.sv
rtl/core/qerpm_ctrl.sv
rtl/core/qerpm_dp.sv
rtl/core/quadrature_encoder_rpm_meter_core.sv
dv/tb_quadrature_encoder_rpm_meter_core.sv
